// ----- rtl/esd_pkg.sv -----
// Shared types, character codes and the hex digit helper
// for the escape sequence decoder. No dependencies.
package esd_pkg;

  localparam logic [7:0] CHR_NUL       = 8'h00;
  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_LOWER_X   = 8'h78;

  typedef enum logic [1:0] {
    PH_PLAIN  = 2'd0,
    PH_ESC    = 2'd1,
    PH_HEX_HI = 2'd2,
    PH_HEX_LO = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  high_nibble;
    logic [15:0] emitted;
    logic        finished;
  } dec_state_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  decoded_byte;
    logic [15:0] byte_count;
    logic        string_done;
  } dec_result_t;

  localparam dec_state_t DEC_STATE_CLEAR = '{
    phase:       PH_PLAIN,
    high_nibble: 4'd0,
    emitted:     16'd0,
    finished:    1'b0
  };

  // Non-hex characters decode as zero.
  function automatic logic [3:0] hex_value(logic [7:0] c);
    logic [7:0] diff;
    diff = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      diff = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      diff = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      diff = c - 8'h57;
    end
    return diff[3:0];
  endfunction

endpackage

// ----- rtl/escape_sequence_decoder_core.sv -----
// Backslash / hex escape decoder: one char in, one result out per cycle when
// out_stall allows. Depends on esd_pkg and esd_step.
//
// Characters enter an input register; the decode step sits between that
// register and the result register, and one character is taken every cycle
// while the result side does not stall. The decoder state (escape phase,
// high nibble, byte count, done flag) advances when a character moves into
// the result register, which sets that rate. The user must write max_bytes
// through cfg_wr_en/cfg_wr_data only while no character is in flight; the
// block itself does not enforce this.
module escape_sequence_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char,
  input  logic        in_first_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_byte_valid,
  output logic [7:0]  out_decoded_byte,
  output logic [15:0] out_byte_count,
  output logic        out_string_done
);

  logic                 max_bytes_r;
  logic [15:0]          max_bytes_val_r;
  logic                 in_vld_r;
  logic [7:0]           in_char_r;
  logic                 in_first_r;
  logic                 out_vld_r;
  esd_pkg::dec_result_t out_res_r;
  esd_pkg::dec_state_t  state_r;
  esd_pkg::dec_state_t  state_nxt;
  esd_pkg::dec_result_t res_nxt;
  logic                 s2_load;
  logic                 s1_load;

  assign s2_load  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !s2_load;
  assign s1_load  = in_valid && !in_stall;

  esd_step u_step (
    .state_i     (state_r),
    .max_bytes_i (max_bytes_val_r),
    .char_i      (in_char_r),
    .first_i     (in_first_r),
    .state_o     (state_nxt),
    .result_o    (res_nxt)
  );

  // max_bytes_r marks that the limit has been written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r     <= 1'b0;
      max_bytes_val_r <= 16'hFFFF;
    end else if (cfg_wr_en) begin
      max_bytes_r     <= 1'b1;
      max_bytes_val_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= esd_pkg::DEC_STATE_CLEAR;
    end else begin
      if (s1_load) begin
        in_vld_r <= 1'b1;
      end else if (s2_load) begin
        in_vld_r <= 1'b0;
      end
      if (s2_load) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      in_char_r  <= in_char;
      in_first_r <= in_first_of_string;
    end
    if (s2_load) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_byte_valid   = out_res_r.byte_valid;
  assign out_decoded_byte = out_res_r.decoded_byte;
  assign out_byte_count   = out_res_r.byte_count;
  assign out_string_done  = out_res_r.string_done;

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.byte_valid) |-> (out_res_r.byte_count != 16'd0))
    else $error("emitted byte with zero count");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_res_r.byte_valid) |-> (out_res_r.decoded_byte == 8'd0))
    else $error("decoded byte nonzero without byte");

  a_done_plain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.finished |-> (state_r.phase == esd_pkg::PH_PLAIN))
    else $error("finished with escape pending");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && state_r.finished && !in_first_r) |=>
      (!out_res_r.byte_valid && out_res_r.string_done))
    else $error("byte emitted after string end");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_load |=> $stable(state_r))
    else $error("decoder state moved without transfer");

  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && max_bytes_r && out_res_r.byte_count >= max_bytes_val_r
     && $stable(max_bytes_val_r)) |-> out_res_r.string_done)
    else $error("limit reached without done");

endmodule

// ----- rtl/esd_step.sv -----
// Combinational decode of one character against the current decoder state.
// Depends on esd_pkg.
module esd_step (
  input  esd_pkg::dec_state_t  state_i,
  input  logic [15:0]          max_bytes_i,
  input  logic [7:0]           char_i,
  input  logic                 first_i,
  output esd_pkg::dec_state_t  state_o,
  output esd_pkg::dec_result_t result_o
);

  esd_pkg::dec_state_t st;
  esd_pkg::dec_state_t nxt;
  logic                emit;
  logic [7:0]          byte_val;
  logic [15:0]         count_inc;

  always_comb begin
    st       = first_i ? esd_pkg::DEC_STATE_CLEAR : state_i;
    nxt      = st;
    emit     = 1'b0;
    byte_val = 8'd0;
    count_inc = st.emitted + 16'd1;
    if (!st.finished) begin
      if (st.emitted >= max_bytes_i || char_i == esd_pkg::CHR_NUL) begin
        nxt.finished = 1'b1;
        nxt.phase    = esd_pkg::PH_PLAIN;
      end else begin
        unique case (st.phase)
          esd_pkg::PH_PLAIN: begin
            if (char_i == esd_pkg::CHR_BACKSLASH) begin
              nxt.phase = esd_pkg::PH_ESC;
            end else begin
              emit     = 1'b1;
              byte_val = char_i;
            end
          end
          esd_pkg::PH_ESC: begin
            if (char_i == esd_pkg::CHR_LOWER_X) begin
              nxt.phase = esd_pkg::PH_HEX_HI;
            end else begin
              emit      = 1'b1;
              byte_val  = char_i;
              nxt.phase = esd_pkg::PH_PLAIN;
            end
          end
          esd_pkg::PH_HEX_HI: begin
            nxt.high_nibble = esd_pkg::hex_value(char_i);
            nxt.phase       = esd_pkg::PH_HEX_LO;
          end
          default: begin
            emit      = 1'b1;
            byte_val  = {st.high_nibble, esd_pkg::hex_value(char_i)};
            nxt.phase = esd_pkg::PH_PLAIN;
          end
        endcase
        if (emit) begin
          nxt.emitted = count_inc;
          if (count_inc >= max_bytes_i) begin
            nxt.finished = 1'b1;
            nxt.phase    = esd_pkg::PH_PLAIN;
          end
        end
      end
    end
  end

  assign state_o                  = nxt;
  assign result_o.byte_valid      = emit;
  assign result_o.decoded_byte    = byte_val;
  assign result_o.byte_count      = nxt.emitted;
  assign result_o.string_done     = nxt.finished;

endmodule
